[rtl/core/huffman_table_encoder_packer_unit_assert.svh]
// Assertion macros for the Huffman table encoder and bit packer.
// Needs clk_i and rst_ni in the including module's scope.
`ifndef HUFFMAN_TABLE_ENCODER_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_PACKER_UNIT_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define HTEP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("htep assertion failed");

// Trigger implies a consequence in the next cycle.
`define HTEP_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("htep assertion failed");

`endif

[rtl/core/htep_pkg.sv]
// Package for the Huffman table encoder and bit packer.
// Operation codes and fixed field widths; no dependencies.
package htep_pkg;

  typedef enum logic [1:0] {
    OpLoad   = 2'd0,
    OpEncode = 2'd1,
    OpFlush  = 2'd2
  } op_e;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned PendW      = 7;
  localparam int unsigned CodeFieldW = 16;
  localparam int unsigned AccW       = PendW + CodeFieldW;
  localparam int unsigned TotalW     = 32;

endpackage

[rtl/core/htep_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No package dependency.
module htep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/huffman_table_encoder_packer_unit.sv]
// Top level of the table-driven Huffman encoder and bit packer.
// Uses htep_pkg, htep_ram and huffman_table_encoder_packer_unit_assert.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_ready_o | operation, symbol, code_bits, code_length
//  out     | output    | out_valid_o/out_ready_i | out_byte, byte_valid, no_code,
//          |           |                         | total_bits, last
//
// Flow: an item reads the code table in its accept cycle and is held in the input
// stage until packing fires; an encode completing two bytes gives two results (the
// second waits in its own slot), a load or ignored operation none, others one.
// Reset: asynchronous, clears control state and the per-entry valid bits, so the
// table reads as all lengths zero at once; no clearing pass.
// Stalls: a waiting result blocks packing, which in turn holds the input side.
module huffman_table_encoder_packer_unit
  import htep_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  symbol_i,
  input  logic [15:0] code_bits_i,
  input  logic [4:0]  code_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        no_code_o,
  output logic [31:0] total_bits_o,
  output logic        last_o
);

  // Effective code length limit; stored code and length shrink with it.
  localparam int unsigned LenLimit = (MAX_CODE_LEN < CodeFieldW) ? MAX_CODE_LEN : CodeFieldW;
  localparam int unsigned LenW     = $clog2(LenLimit + 1);
  localparam int unsigned CodeW    = LenLimit;
  localparam int unsigned EntryW   = CodeW + LenW;
  localparam int unsigned IdxW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // ---------------------------------------------------------------------------
  // Input stage: table write for loads, table read for encodes
  // ---------------------------------------------------------------------------
  logic            in_xfer;
  logic            in_range;
  logic [IdxW-1:0] in_idx;
  logic [LenW-1:0] len_clamped;
  logic            s1_fire;

  logic            s1_valid_q;
  op_e             s1_op_q;
  logic            s1_hit_q;

  logic            entry_valid_q [SYMBOL_COUNT];
  logic [EntryW-1:0] rd_entry;

  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_range   = (9'(symbol_i) < 9'(SYMBOL_COUNT));
  assign in_idx     = symbol_i[IdxW-1:0];

  // Overlong lengths clamp to the limit.
  assign len_clamped = (code_length_i > 5'(LenLimit)) ? LenW'(LenLimit)
                                                      : code_length_i[LenW-1:0];

  htep_ram #(
    .WIDTH (EntryW),
    .DEPTH (SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (operation_i == OpLoad) && in_range),
    .waddr_i (in_idx),
    .wdata_i ({code_bits_i[CodeW-1:0], len_clamped}),
    .re_i    (in_xfer && (operation_i == OpEncode) && in_range),
    .raddr_i (in_idx),
    .rdata_o (rd_entry)
  );

  // Valid bits stand for the all-zero reset of the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
        entry_valid_q[i] <= 1'b0;
      end
    end else if (in_xfer && (operation_i == OpLoad) && in_range) begin
      entry_valid_q[in_idx] <= 1'b1;
    end
  end

  // Only encode and flush reach the packing stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_op_q    <= OpLoad;
      s1_hit_q   <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_xfer && ((operation_i == OpEncode) || (operation_i == OpFlush));
      s1_op_q    <= op_e'(operation_i);
      s1_hit_q   <= in_range && entry_valid_q[in_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Packing stage
  // ---------------------------------------------------------------------------
  logic [PendW-1:0]  pend_bits_q, pend_bits_d;
  logic [2:0]        pend_cnt_q, pend_cnt_d;
  logic [TotalW-1:0] total_q, total_d;

  logic [LenW-1:0]       len;
  logic [CodeFieldW-1:0] code_pad, code_m;
  logic [AccW-1:0]       acc;
  logic [4:0]            nbits;
  logic [TotalW:0]       sum;

  // Result A goes to the output register, result B to the second slot.
  logic [7:0] a_byte, b_byte;
  logic       a_bvalid, a_nocode, a_last, b_valid;

  logic        out_valid_q, sec_valid_q;
  logic [7:0]  out_byte_q, sec_byte_q;
  logic        byte_valid_q, no_code_q, last_q;
  logic [31:0] tot_out_q;

  assign s1_fire = s1_valid_q && (!out_valid_q || out_ready_i) && !sec_valid_q;

  assign len      = s1_hit_q ? rd_entry[LenW-1:0] : '0;
  assign code_pad = CodeFieldW'(rd_entry[EntryW-1:LenW]);

  always_comb begin
    for (int i = 0; i < CodeFieldW; i++) begin
      code_m[i] = code_pad[i] && (5'(i) < 5'(len));
    end
  end

  assign acc   = (AccW'(code_m) << pend_cnt_q) | AccW'(pend_bits_q);
  assign nbits = 5'(pend_cnt_q) + 5'(len);
  assign sum   = {1'b0, total_q} + (TotalW + 1)'(len);

  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    total_d     = total_q;
    a_byte      = 8'h00;
    a_bvalid    = 1'b0;
    a_nocode    = 1'b0;
    a_last      = 1'b1;
    b_byte      = 8'h00;
    b_valid     = 1'b0;
    unique case (s1_op_q)
      OpEncode: begin
        if (len == '0) begin
          // symbol without code: flag only, state untouched
          a_nocode = 1'b1;
        end else begin
          total_d    = sum[TotalW] ? '1 : sum[TotalW-1:0];
          pend_cnt_d = nbits[2:0];
          if (nbits >= 5'(2 * ByteBits)) begin
            a_byte      = acc[7:0];
            a_bvalid    = 1'b1;
            a_last      = 1'b0;
            b_byte      = acc[15:8];
            b_valid     = 1'b1;
            pend_bits_d = acc[22:16];
          end else if (nbits >= 5'(ByteBits)) begin
            a_byte      = acc[7:0];
            a_bvalid    = 1'b1;
            pend_bits_d = acc[14:8];
          end else begin
            pend_bits_d = acc[6:0];
          end
        end
      end
      OpFlush: begin
        if (pend_cnt_q != 3'd0) begin
          a_byte   = {1'b0, pend_bits_q};
          a_bvalid = 1'b1;
        end
        pend_bits_d = '0;
        pend_cnt_d  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      total_q     <= '0;
    end else if (s1_fire) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      total_q     <= total_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and second-byte slot
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
      sec_valid_q <= b_valid;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_q <= sec_valid_q;
      sec_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_byte_q   <= a_byte;
      byte_valid_q <= a_bvalid;
      no_code_q    <= a_nocode;
      last_q       <= a_last;
      tot_out_q    <= total_d;
      sec_byte_q   <= b_byte;
    end else if (out_valid_q && out_ready_i && sec_valid_q) begin
      // second byte of a two-byte encode; total stays
      out_byte_q   <= sec_byte_q;
      byte_valid_q <= 1'b1;
      no_code_q    <= 1'b0;
      last_q       <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign no_code_o    = no_code_q;
  assign total_bits_o = tot_out_q;
  assign last_o       = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "huffman_table_encoder_packer_unit_assert.svh"

  `HTEP_ASSERT(a_sec_needs_out, !sec_valid_q || out_valid_q)
  `HTEP_ASSERT(a_first_of_two, !sec_valid_q || (byte_valid_q && !last_q && !no_code_q))
  `HTEP_ASSERT_NEXT(a_sec_moves_up, out_valid_q && out_ready_i && sec_valid_q,
                    out_valid_q && last_q && byte_valid_q && !sec_valid_q)
  `HTEP_ASSERT_NEXT(a_flush_clears, s1_fire && (s1_op_q == OpFlush),
                    (pend_cnt_q == 3'd0) && (pend_bits_q == '0))

endmodule

[sim/huffman_table_encoder_packer_unit_tb.sv]
// Self-checking testbench for huffman_table_encoder_packer_unit: code table loads,
// symbol encoding, bit packing and flushes, checked against an in-bench predictor.
// Depends on htep_pkg and the RTL top level only.
module huffman_table_encoder_packer_unit_tb
  import htep_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCodeLen    = 16;
  localparam int unsigned SymbolCount   = 256;
  localparam int unsigned CodeLenLimit  = (MaxCodeLen < CodeFieldW) ? MaxCodeLen : CodeFieldW;
  localparam int          ClkPeriod     = 8;
  localparam int          ResetCycles   = 8;
  localparam int          RandomItems   = 700;
  localparam int          HoldCycles    = 240;
  localparam int          DrainCycles   = 16;
  localparam int          TimeoutCycles = 400_000;
  localparam int          MaxReported   = 10;
  // Operation code the block must ignore.
  localparam logic [1:0]  OpUnused      = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [15:0] bits;
    logic [4:0]  len;
  } coder_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        no_code;
    logic [31:0] total_bits;
    logic        last;
  } packed_result_t;

  // DUT connections
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OpLoad;
  logic [7:0]  symbol_i = '0;
  logic [15:0] code_bits_i = '0;
  logic [4:0]  code_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        no_code_o;
  logic [31:0] total_bits_o;
  logic        last_o;

  huffman_table_encoder_packer_unit #(
    .MAX_CODE_LEN(MaxCodeLen),
    .SYMBOL_COUNT(SymbolCount)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .symbol_i     (symbol_i),
    .code_bits_i  (code_bits_i),
    .code_length_i(code_length_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .no_code_o    (no_code_o),
    .total_bits_o (total_bits_o),
    .last_o       (last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Items waiting to be offered, and results the predictor says are still owed.
  coder_item_t    coder_items_q[$];
  packed_result_t packed_results_q[$];

  // Predictor state: its own copy of the code table and the packing registers.
  logic [15:0] tbl_bits[SymbolCount];
  logic [4:0]  tbl_len[SymbolCount];
  logic [6:0]  pend_bits;
  logic [2:0]  pend_cnt;
  logic [31:0] bit_total;

  // Bookkeeping
  int n_directed;
  int n_sent;
  int stim_phase;
  int mismatch_count;
  int n_loads, n_encodes, n_flushes, n_ignored;
  int n_results, n_bytes, n_no_code;
  logic rx_hold = 1'b0;
  coder_item_t nxt_item;
  packed_result_t exp_res, got_res;

  task automatic add_item(input logic [1:0] op, input logic [7:0] sym,
                          input logic [15:0] bits, input logic [4:0] len);
    coder_item_t it;
    it.op   = op;
    it.sym  = sym;
    it.bits = bits;
    it.len  = len;
    coder_items_q = {coder_items_q, it};
  endtask

  // Works out every result one accepted item causes and queues them in order.
  task automatic encode_and_pack(input coder_item_t it);
    logic [4:0]     clen;
    logic [31:0]    code;
    logic [31:0]    acc;
    logic [32:0]    sum;
    int             n;
    int             k;
    packed_result_t r;
    r = '0;
    k = 0;
    case (it.op)
      OpLoad: begin
        clen = (it.len > CodeLenLimit) ? 5'(CodeLenLimit) : it.len;
        if (it.sym < SymbolCount) begin
          tbl_bits[it.sym] = it.bits;
          tbl_len[it.sym]  = clen;
        end
      end
      OpEncode: begin
        clen = (it.sym < SymbolCount) ? tbl_len[it.sym] : 5'd0;
        if (clen == 0) begin
          // symbol without a code: flag only, state untouched
          r.no_code    = 1'b1;
          r.total_bits = bit_total;
          r.last       = 1'b1;
          packed_results_q = {packed_results_q, r};
        end else begin
          code      = {16'd0, tbl_bits[it.sym]} & ((32'd1 << clen) - 32'd1);
          sum       = {1'b0, bit_total} + 33'(clen);
          bit_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          acc       = {25'd0, pend_bits} | (code << pend_cnt);
          n         = int'(pend_cnt) + int'(clen);
          while (n >= ByteBits && k < 2) begin
            r.out_byte   = acc[7:0];
            r.byte_valid = 1'b1;
            r.no_code    = 1'b0;
            r.total_bits = bit_total;
            r.last       = ((n - ByteBits) < ByteBits) || (k == 1);
            packed_results_q = {packed_results_q, r};
            acc = acc >> ByteBits;
            n   = n - ByteBits;
            k++;
          end
          pend_bits = acc[6:0];
          pend_cnt  = 3'(n);
          if (k == 0) begin
            r.total_bits = bit_total;
            r.last       = 1'b1;
            packed_results_q = {packed_results_q, r};
          end
        end
      end
      OpFlush: begin
        if (pend_cnt != 0) begin
          r.out_byte   = {1'b0, pend_bits};
          r.byte_valid = 1'b1;
        end
        r.total_bits = bit_total;
        r.last       = 1'b1;
        packed_results_q = {packed_results_q, r};
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: ;
    endcase
  endtask

  // Sender: offers queued items; idling depends on the phase of the run.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      // previous transfer done (or nothing offered), so a new item may go out
      if (coder_items_q.size() != 0 &&
          !((stim_phase == 1 && $urandom_range(99) < 75) ||
            (stim_phase == 3 && $urandom_range(99) < 24))) begin
        nxt_item = coder_items_q.pop_front();
        operation_i   <= nxt_item.op;
        symbol_i      <= nxt_item.sym;
        code_bits_i   <= nxt_item.bits;
        code_length_i <= nxt_item.len;
        in_valid_i    <= 1'b1;
        n_sent++;
        if (n_sent > n_directed)
          stim_phase = ((n_sent - n_directed - 1) * 4) / (n_sent > n_directed ?
                       (coder_items_q.size() + n_sent - n_directed) : 1);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: ready pattern per phase, overridden by the long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold) begin
      out_ready_i <= 1'b0;
    end else begin
      case (stim_phase)
        2:       out_ready_i <= ($urandom_range(99) >= 75);
        3:       out_ready_i <= ($urandom_range(99) >= 24);
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  // Long hold-off on the output while the sender keeps going at full rate,
  // so the block backs up and drops in_ready_o.
  initial begin
    while (n_directed == 0 || n_sent < n_directed + 60) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Monitor: output transfers are checked before the input transfer of the same
  // edge is predicted; a result can never belong to an item accepted this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_res = '{out_byte_o, byte_valid_o, no_code_o, total_bits_o, last_o};
        n_results++;
        if (packed_results_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported)
            $display("%0t: result with nothing owed: byte %02h bv %0b nc %0b total %0d last %0b",
                     $realtime, got_res.out_byte, got_res.byte_valid, got_res.no_code,
                     got_res.total_bits, got_res.last);
        end else begin
          exp_res = packed_results_q.pop_front();
          if (got_res.byte_valid && exp_res.byte_valid) n_bytes++;
          if (exp_res.no_code) n_no_code++;
          if (got_res.out_byte !== exp_res.out_byte ||
              got_res.byte_valid !== exp_res.byte_valid ||
              got_res.no_code !== exp_res.no_code ||
              got_res.total_bits !== exp_res.total_bits ||
              got_res.last !== exp_res.last) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported) begin
              $write("%0t: mismatch: exp byte %02h bv %0b nc %0b total %0d last %0b",
                     $realtime, exp_res.out_byte, exp_res.byte_valid, exp_res.no_code,
                     exp_res.total_bits, exp_res.last);
              $display(" / got byte %02h bv %0b nc %0b total %0d last %0b",
                       got_res.out_byte, got_res.byte_valid, got_res.no_code,
                       got_res.total_bits, got_res.last);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        case (operation_i)
          OpLoad:   n_loads++;
          OpEncode: n_encodes++;
          OpFlush:  n_flushes++;
          default:  n_ignored++;
        endcase
        encode_and_pack('{operation_i, symbol_i, code_bits_i, code_length_i});
      end
    end
  end

  // Watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("huffman_table_encoder_packer_unit_tb: errors");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    int r;
    int counted;
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [4:0]  len;
    rst_ni         = 1'b0;
    n_directed     = 0;
    n_sent         = 0;
    stim_phase     = 0;
    mismatch_count = 0;
    n_loads = 0; n_encodes = 0; n_flushes = 0; n_ignored = 0;
    n_results = 0; n_bytes = 0; n_no_code = 0;
    for (int i = 0; i < SymbolCount; i++) begin
      tbl_bits[i] = '0;
      tbl_len[i]  = '0;
    end
    pend_bits = '0;
    pend_cnt  = '0;
    bit_total = '0;

    // Directed part
    add_item(OpEncode, 8'd0,   16'h0000, 5'd0);   // table empty after reset: no code
    add_item(OpEncode, 8'd255, 16'hFFFF, 5'd31);  // same at the top entry
    add_item(OpFlush,  8'd0,   16'h0000, 5'd0);   // nothing pending
    add_item(OpLoad,   8'd0,   16'hFFFF, 5'd16);  // longest code, all ones
    add_item(OpLoad,   8'd255, 16'h0000, 5'd1);   // shortest code, a single zero
    add_item(OpLoad,   8'd1,   16'hA5C3, 5'd31);  // overlong length, clamped
    add_item(OpLoad,   8'd2,   16'h0001, 5'd0);   // explicit zero length
    add_item(OpLoad,   8'd3,   16'h0005, 5'd3);
    add_item(OpLoad,   8'd4,   16'h5A3C, 5'd17);  // just above the limit
    add_item(OpLoad,   8'd5,   16'hFF6B, 5'd8);   // junk above the code length
    add_item(OpEncode, 8'd0,   16'h0000, 5'd0);   // two whole bytes
    add_item(OpEncode, 8'd3,   16'hFFFF, 5'd31);  // partial only
    add_item(OpEncode, 8'd0,   16'h0000, 5'd0);   // two bytes plus a remainder
    add_item(OpEncode, 8'd1,   16'h0000, 5'd0);
    add_item(OpFlush,  8'd0,   16'h0000, 5'd0);   // partial byte out
    add_item(OpFlush,  8'd0,   16'h0000, 5'd0);   // now empty
    add_item(OpEncode, 8'd2,   16'h0000, 5'd0);   // zero-length entry
    add_item(OpUnused, 8'd3,   16'hFFFF, 5'd31);  // ignored operation
    add_item(OpEncode, 8'd255, 16'h0000, 5'd0);
    add_item(OpEncode, 8'd5,   16'h0000, 5'd0);
    add_item(OpEncode, 8'd4,   16'h0000, 5'd0);
    add_item(OpEncode, 8'd3,   16'h0000, 5'd0);
    add_item(OpFlush,  8'd255, 16'hFFFF, 5'd31);
    n_directed = coder_items_q.size();

    // Random part: give the hot symbols a code first, then mostly encodes of them
    // with loads, flushes and the odd ignored item mixed in.
    for (int i = 0; i < 16; i++)
      add_item(OpLoad, 8'(i), 16'($urandom), 5'($urandom_range(CodeLenLimit, 1)));
    counted = 16;
    while (counted < RandomItems) begin
      r = $urandom_range(99);
      if (r < 15)      op = OpLoad;
      else if (r < 82) op = OpEncode;
      else if (r < 95) op = OpFlush;
      else             op = OpUnused;
      sym = ($urandom_range(99) < 80) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      len = 5'($urandom);
      if (op == OpLoad) begin
        r = $urandom_range(99);
        if (r < 6)       len = 5'd0;
        else if (r < 16) len = 5'($urandom_range(31, 17));
        else             len = 5'($urandom_range(CodeLenLimit, 1));
      end
      add_item(op, sym, 16'($urandom), len);
      if (op != OpUnused) counted++;
    end

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (coder_items_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (packed_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (packed_results_q.size() != 0) mismatch_count++;

    $display("run: %0d loads, %0d encodes, %0d flushes, %0d ignored items transferred",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("     %0d results (%0d packed bytes, %0d no-code), %0d mismatches",
             n_results, n_bytes, n_no_code, mismatch_count);
    if (mismatch_count == 0) begin
      $display("huffman_table_encoder_packer_unit_tb: clean");
    end else begin
      $display("huffman_table_encoder_packer_unit_tb: errors");
    end
    $finish;
  end

endmodule

[huffman_table_encoder_packer_unit.f]
+incdir+rtl/core
rtl/core/htep_pkg.sv
rtl/core/htep_ram.sv
rtl/core/huffman_table_encoder_packer_unit.sv
sim/huffman_table_encoder_packer_unit_tb.sv
